FILE: design/pcenc_pkg.sv
// Package for the label encoder: widths, algorithm constants, shared types
// and the digit-to-character function. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package pcenc_pkg;
    localparam int CP_W   = 21;
    localparam int CH_W   = 7;
    localparam int DVD_W  = 32;
    localparam int DVS_W  = 10;
    localparam int BIAS_W = 10;
    localparam int N_W    = 22;

    localparam int MAX_LABEL_IN_DEF  = 63;
    localparam int MAX_LABEL_OUT_DEF = 63;

    localparam logic [N_W-1:0]    INIT_N    = N_W'(128);
    localparam logic [BIAS_W-1:0] INIT_BIAS = BIAS_W'(72);
    localparam logic [BIAS_W-1:0] BASE      = BIAS_W'(36);
    localparam logic [BIAS_W-1:0] TMAX      = BIAS_W'(26);
    localparam logic [DVS_W-1:0]  SKEW      = DVS_W'(38);
    localparam logic [DVD_W-1:0]  ADAPT_LIM = DVD_W'((35 * 26) / 2);

    // Reciprocal constants: x / 700 is ((x >> 2) * DIV700_MUL) >> DIV700_SH and
    // x / 35 is (x * DIV35_MUL) >> DIV35_SH, exact for every 32-bit x.
    localparam logic [29:0] DIV700_MUL = 30'd785365449;
    localparam int          DIV700_SH  = 37;
    localparam logic [32:0] DIV35_MUL  = 33'd7853654485;
    localparam int          DIV35_SH   = 38;

    localparam logic [CH_W-1:0] CH_X      = CH_W'(8'h78);
    localparam logic [CH_W-1:0] CH_N      = CH_W'(8'h6E);
    localparam logic [CH_W-1:0] CH_HYPHEN = CH_W'(8'h2D);

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            last;
        logic            basic;
    } t_item;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quot;
        logic [DVS_W-1:0] rem;
    } t_div_rsp;

    function automatic logic [CH_W-1:0] digit_char(input logic [5:0] d);
        if (d < 6'd26) begin
            return CH_W'(7'h61 + {1'b0, d});
        end else begin
            return CH_W'(7'h16 + {1'b0, d});
        end
    endfunction
endpackage
`default_nettype wire

FILE: design/pcenc_front.sv
// Front part: takes code points, marks basic ones and queues them in a
// two-entry queue for the encoder. Depends on pcenc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pcenc_front (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    output logic                        o_full,
    input  wire logic [pcenc_pkg::CP_W-1:0] i_code_point,
    input  wire logic                   i_last,
    output logic                        o_valid,
    output pcenc_pkg::t_item            o_item,
    input  wire logic                   i_take
);
    import pcenc_pkg::*;

    t_item       r_mem [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        w_wr, w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= !r_wp;
            end
            if (w_rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp].code_point <= i_code_point;
            r_mem[r_wp].last       <= i_last;
            r_mem[r_wp].basic      <= (i_code_point[CP_W-1:7] == '0);
        end
    end
endmodule
`default_nettype wire

FILE: design/pcenc_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on pcenc_pkg for widths and request/response types.
`timescale 1ns / 1ps
`default_nettype none
module pcenc_div (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire pcenc_pkg::t_div_req i_req,
    output pcenc_pkg::t_div_rsp o_rsp
);
    import pcenc_pkg::*;

    logic [DVS_W:0]   r_rem;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_dvs;
    logic [5:0]       r_cnt;
    logic             r_busy, r_done;
    logic [DVS_W:0]   w_sh;
    logic [DVS_W+1:0] w_trial;

    assign w_sh    = {r_rem[DVS_W-1:0], r_quo[DVD_W-1]};
    assign w_trial = {1'b0, w_sh} - {2'b00, r_dvs};

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem[DVS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            if (!w_trial[DVS_W+1]) begin
                r_rem <= w_trial[DVS_W:0];
                r_quo <= {r_quo[DVD_W-2:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_quo <= {r_quo[DVD_W-2:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

FILE: design/pcenc_back.sv
// Back part: stores the label, runs the encoding sequence, buffers the
// result characters and streams them out. Depends on pcenc_pkg, pcenc_div.
`timescale 1ns / 1ps
`default_nettype none
module pcenc_back #(
    parameter int MAX_LABEL_IN  = pcenc_pkg::MAX_LABEL_IN_DEF,
    parameter int MAX_LABEL_OUT = pcenc_pkg::MAX_LABEL_OUT_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    input  wire pcenc_pkg::t_item        i_item,
    output logic                         o_take,
    output logic                         o_empty,
    input  wire logic                    i_pop,
    output logic [pcenc_pkg::CH_W-1:0]   o_character,
    output logic                         o_last_res,
    output logic                         o_overflow
);
    import pcenc_pkg::*;

    localparam int LW  = $clog2(MAX_LABEL_IN + 1);
    localparam int IW  = (MAX_LABEL_IN > 1) ? $clog2(MAX_LABEL_IN) : 1;
    localparam int OCW = $clog2(MAX_LABEL_OUT + 1);
    localparam int OIW = $clog2(MAX_LABEL_OUT);

    localparam logic [4:0] S_COLLECT  = 5'd0;
    localparam logic [4:0] S_PLAIN_RD = 5'd1;
    localparam logic [4:0] S_PLAIN_US = 5'd2;
    localparam logic [4:0] S_PREFIX   = 5'd3;
    localparam logic [4:0] S_BAS_RD   = 5'd4;
    localparam logic [4:0] S_BAS_US   = 5'd5;
    localparam logic [4:0] S_HYPH     = 5'd6;
    localparam logic [4:0] S_INIT     = 5'd7;
    localparam logic [4:0] S_LOOP     = 5'd8;
    localparam logic [4:0] S_MIN_RD   = 5'd9;
    localparam logic [4:0] S_MIN_US   = 5'd10;
    localparam logic [4:0] S_DELTA    = 5'd11;
    localparam logic [4:0] S_SCAN_RD  = 5'd12;
    localparam logic [4:0] S_SCAN_US  = 5'd13;
    localparam logic [4:0] S_DIG      = 5'd14;
    localparam logic [4:0] S_DIG_W    = 5'd15;
    localparam logic [4:0] S_AD1      = 5'd16;
    localparam logic [4:0] S_AD2      = 5'd18;
    localparam logic [4:0] S_AD2_W    = 5'd19;
    localparam logic [4:0] S_AD3      = 5'd20;
    localparam logic [4:0] S_AD4_W    = 5'd22;
    localparam logic [4:0] S_NEXT     = 5'd23;
    localparam logic [4:0] S_LOOP_END = 5'd24;
    localparam logic [4:0] S_EMIT_RD  = 5'd25;
    localparam logic [4:0] S_EMIT_US  = 5'd26;
    localparam logic [4:0] S_OVF_OUT  = 5'd27;

    logic [CP_W-1:0] r_lmem [MAX_LABEL_IN];
    logic [CH_W-1:0] r_omem [MAX_LABEL_OUT];
    logic [CP_W-1:0] r_lrd;
    logic [CH_W-1:0] r_ord;

    logic [4:0]        r_state, n_state;
    logic [LW-1:0]     r_len, n_len, r_basic, n_basic, r_h, n_h;
    logic              r_ovf_in, n_ovf_in, r_nb, n_nb;
    logic [IW-1:0]     r_idx, n_idx;
    logic [N_W-1:0]    r_n, n_n, r_m, n_m;
    logic [DVD_W-1:0]  r_delta, n_delta, r_q, n_q;
    logic [BIAS_W-1:0] r_bias, n_bias, r_k, n_k;
    logic [4:0]        r_t, n_t;
    logic [1:0]        r_pc, n_pc;
    logic [OCW-1:0]    r_ocnt, n_ocnt;
    logic [OIW-1:0]    r_oidx, n_oidx;
    logic              r_ov, n_ov, r_ol, n_ol, r_of, n_of;
    logic [CH_W-1:0]   r_oc, n_oc;

    logic              w_put;
    logic [CH_W-1:0]   w_ch;
    logic              w_store;
    logic              w_idx_last;
    logic [N_W-1:0]    w_c;
    logic [4:0]        w_tv;
    logic [BIAS_W:0]   w_bt;
    logic              w_ofree;
    logic [59:0]       w_p700;
    logic [64:0]       w_p35;
    t_div_req          w_req;
    t_div_rsp          w_rsp;

    pcenc_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    assign w_store    = (r_state == S_COLLECT) && i_valid && (r_len < LW'(MAX_LABEL_IN));
    assign w_idx_last = (LW'(r_idx) == r_len - LW'(1));
    assign w_c        = {1'b0, r_lrd};
    assign w_bt       = {1'b0, r_bias} + {1'b0, TMAX};
    assign w_ofree    = !r_ov || i_pop;
    assign w_p700     = 60'(r_delta[DVD_W-1:2]) * 60'(DIV700_MUL);
    assign w_p35      = 65'(r_q) * 65'(DIV35_MUL);

    always_comb begin
        if (r_k <= r_bias) begin
            w_tv = 5'd1;
        end else if ({1'b0, r_k} >= w_bt) begin
            w_tv = 5'd26;
        end else begin
            w_tv = 5'(r_k - r_bias);
        end
    end

    assign o_empty     = !r_ov;
    assign o_character = r_oc;
    assign o_last_res  = r_ol;
    assign o_overflow  = r_of;

    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_basic  = r_basic;
        n_h      = r_h;
        n_ovf_in = r_ovf_in;
        n_nb     = r_nb;
        n_idx    = r_idx;
        n_n      = r_n;
        n_m      = r_m;
        n_delta  = r_delta;
        n_q      = r_q;
        n_bias   = r_bias;
        n_k      = r_k;
        n_t      = r_t;
        n_pc     = r_pc;
        n_ocnt   = r_ocnt;
        n_oidx   = r_oidx;
        n_ov     = r_ov && !i_pop;
        n_oc     = r_oc;
        n_ol     = r_ol;
        n_of     = r_of;
        o_take   = 1'b0;
        w_put    = 1'b0;
        w_ch     = '0;
        w_req    = '0;
        unique case (r_state)
            S_COLLECT: begin
                if (i_valid) begin
                    o_take = 1'b1;
                    if (w_store) begin
                        n_len = r_len + LW'(1);
                        if (i_item.basic) begin
                            n_basic = r_basic + LW'(1);
                        end else begin
                            n_nb = 1'b1;
                        end
                    end else begin
                        n_ovf_in = 1'b1;
                    end
                    if (i_item.last) begin
                        n_ocnt = '0;
                        n_idx  = '0;
                        n_pc   = '0;
                        if (!w_store || r_ovf_in) begin
                            n_state = S_OVF_OUT;
                        end else if (!i_item.basic || r_nb) begin
                            n_state = S_PREFIX;
                        end else begin
                            n_state = S_PLAIN_RD;
                        end
                    end
                end
            end
            S_PLAIN_RD: n_state = S_PLAIN_US;
            S_PLAIN_US: begin
                w_put = 1'b1;
                w_ch  = r_lrd[CH_W-1:0];
                if (w_idx_last) begin
                    n_oidx  = '0;
                    n_state = S_EMIT_RD;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = S_PLAIN_RD;
                end
            end
            S_PREFIX: begin
                w_put = 1'b1;
                unique case (r_pc)
                    2'd0:    w_ch = CH_X;
                    2'd1:    w_ch = CH_N;
                    default: w_ch = CH_HYPHEN;
                endcase
                n_pc = r_pc + 2'd1;
                if (r_pc == 2'd3) begin
                    n_state = S_BAS_RD;
                end
            end
            S_BAS_RD: n_state = S_BAS_US;
            S_BAS_US: begin
                if (r_lrd[CP_W-1:7] == '0) begin
                    w_put = 1'b1;
                    w_ch  = r_lrd[CH_W-1:0];
                end
                if (w_idx_last) begin
                    n_state = (r_basic != '0) ? S_HYPH : S_INIT;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = S_BAS_RD;
                end
            end
            S_HYPH: begin
                w_put   = 1'b1;
                w_ch    = CH_HYPHEN;
                n_state = S_INIT;
            end
            S_INIT: begin
                n_n     = INIT_N;
                n_delta = '0;
                n_bias  = INIT_BIAS;
                n_h     = r_basic;
                n_state = S_LOOP;
            end
            S_LOOP: begin
                if (r_h < r_len) begin
                    n_m     = '1;
                    n_idx   = '0;
                    n_state = S_MIN_RD;
                end else begin
                    n_oidx  = '0;
                    n_state = S_EMIT_RD;
                end
            end
            S_MIN_RD: n_state = S_MIN_US;
            S_MIN_US: begin
                if (w_c >= r_n && w_c < r_m) begin
                    n_m = w_c;
                end
                if (w_idx_last) begin
                    n_state = S_DELTA;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = S_MIN_RD;
                end
            end
            S_DELTA: begin
                n_delta = r_delta + DVD_W'(r_m[CP_W-1:0] - r_n[CP_W-1:0])
                          * DVD_W'({1'b0, r_h} + (LW + 1)'(1));
                n_n     = r_m;
                n_idx   = '0;
                n_state = S_SCAN_RD;
            end
            S_SCAN_RD: n_state = S_SCAN_US;
            S_SCAN_US: begin
                if (w_c == r_n) begin
                    n_q     = r_delta;
                    n_k     = BASE;
                    n_state = S_DIG;
                end else begin
                    if (w_c < r_n) begin
                        n_delta = r_delta + DVD_W'(1);
                    end
                    n_state = S_NEXT;
                end
            end
            S_DIG: begin
                n_t = w_tv;
                if (r_q < DVD_W'(w_tv)) begin
                    w_put   = 1'b1;
                    w_ch    = digit_char(r_q[5:0]);
                    n_state = S_AD1;
                end else begin
                    w_req.start    = 1'b1;
                    w_req.dividend = r_q - DVD_W'(w_tv);
                    w_req.divisor  = DVS_W'(6'd36 - {1'b0, w_tv});
                    n_state        = S_DIG_W;
                end
            end
            S_DIG_W: begin
                if (w_rsp.done) begin
                    w_put   = 1'b1;
                    w_ch    = digit_char(6'({1'b0, r_t} + w_rsp.rem[5:0]));
                    n_q     = w_rsp.quot;
                    n_k     = r_k + BASE;
                    n_state = S_DIG;
                end
            end
            S_AD1: begin
                if (r_h == r_basic) begin
                    n_q = DVD_W'(w_p700 >> DIV700_SH);
                end else begin
                    n_q = {1'b0, r_delta[DVD_W-1:1]};
                end
                n_state = S_AD2;
            end
            S_AD2: begin
                w_req.start    = 1'b1;
                w_req.dividend = r_q;
                w_req.divisor  = DVS_W'({1'b0, r_h} + (LW + 1)'(1));
                n_state        = S_AD2_W;
            end
            S_AD2_W: begin
                if (w_rsp.done) begin
                    n_q     = r_q + w_rsp.quot;
                    n_k     = '0;
                    n_state = S_AD3;
                end
            end
            S_AD3: begin
                if (r_q > ADAPT_LIM) begin
                    n_q = DVD_W'(w_p35 >> DIV35_SH);
                    n_k = r_k + BASE;
                end else begin
                    w_req.start    = 1'b1;
                    w_req.dividend = DVD_W'(r_q[DVS_W-1:0]) * DVD_W'(36);
                    w_req.divisor  = r_q[DVS_W-1:0] + SKEW;
                    n_state        = S_AD4_W;
                end
            end
            S_AD4_W: begin
                if (w_rsp.done) begin
                    n_bias  = r_k + BIAS_W'(w_rsp.quot[BIAS_W-1:0]);
                    n_delta = '0;
                    n_h     = r_h + LW'(1);
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (w_idx_last) begin
                    n_state = S_LOOP_END;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_LOOP_END: begin
                n_delta = r_delta + DVD_W'(1);
                n_n     = r_n + N_W'(1);
                n_state = S_LOOP;
            end
            S_EMIT_RD: n_state = S_EMIT_US;
            S_EMIT_US: begin
                if (w_ofree) begin
                    n_ov = 1'b1;
                    n_oc = r_ord;
                    n_of = 1'b0;
                    n_ol = (OCW'(r_oidx) == r_ocnt - OCW'(1));
                    if (n_ol) begin
                        n_len    = '0;
                        n_basic  = '0;
                        n_ovf_in = 1'b0;
                        n_nb     = 1'b0;
                        n_state  = S_COLLECT;
                    end else begin
                        n_oidx  = r_oidx + OIW'(1);
                        n_state = S_EMIT_RD;
                    end
                end
            end
            S_OVF_OUT: begin
                if (w_ofree) begin
                    n_ov     = 1'b1;
                    n_oc     = '0;
                    n_ol     = 1'b1;
                    n_of     = 1'b1;
                    n_len    = '0;
                    n_basic  = '0;
                    n_ovf_in = 1'b0;
                    n_nb     = 1'b0;
                    n_state  = S_COLLECT;
                end
            end
            default: n_state = S_COLLECT;
        endcase
        if (w_put) begin
            if (r_ocnt == OCW'(MAX_LABEL_OUT)) begin
                n_state = S_OVF_OUT;
            end else begin
                n_ocnt = r_ocnt + OCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_COLLECT;
            r_len    <= '0;
            r_basic  <= '0;
            r_ovf_in <= 1'b0;
            r_nb     <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_basic  <= n_basic;
            r_ovf_in <= n_ovf_in;
            r_nb     <= n_nb;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h     <= n_h;
        r_idx   <= n_idx;
        r_n     <= n_n;
        r_m     <= n_m;
        r_delta <= n_delta;
        r_q     <= n_q;
        r_bias  <= n_bias;
        r_k     <= n_k;
        r_t     <= n_t;
        r_pc    <= n_pc;
        r_ocnt  <= n_ocnt;
        r_oidx  <= n_oidx;
        r_oc    <= n_oc;
        r_ol    <= n_ol;
        r_of    <= n_of;
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_lmem[r_len[IW-1:0]] <= i_item.code_point;
        end
        r_lrd <= r_lmem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (w_put && r_ocnt < OCW'(MAX_LABEL_OUT)) begin
            r_omem[r_ocnt[OIW-1:0]] <= w_ch;
        end
        r_ord <= r_omem[r_oidx];
    end
endmodule
`default_nettype wire

FILE: design/punycode_label_encoder.sv
// Punycode label encoder top level: input queue, encoder back end and the
// shared divider inside it. Depends on pcenc_pkg, pcenc_front, pcenc_back.
// Items are taken while a label is collected; the last item starts encoding,
// which rescans the stored label per distinct code point and waits on the
// shared divider at each divider step. Characters leave as the output is
// popped. Synchronous active-low reset empties the input queue and output
// register and clears the label counts and the state machines.
`timescale 1ns / 1ps
`default_nettype none
module punycode_label_encoder #(
    parameter int MAX_LABEL_IN  = pcenc_pkg::MAX_LABEL_IN_DEF,
    parameter int MAX_LABEL_OUT = pcenc_pkg::MAX_LABEL_OUT_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic [pcenc_pkg::CP_W-1:0] i_code_point,
    input  wire logic                       i_last,
    output logic                            empty,
    input  wire logic                       pop,
    output logic [pcenc_pkg::CH_W-1:0]      o_character,
    output logic                            o_last_res,
    output logic                            o_overflow
);
    import pcenc_pkg::*;

    logic  w_valid, w_take;
    t_item w_item;

    pcenc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_code_point(i_code_point),
        .i_last      (i_last),
        .o_valid     (w_valid),
        .o_item      (w_item),
        .i_take      (w_take)
    );

    pcenc_back #(
        .MAX_LABEL_IN (MAX_LABEL_IN),
        .MAX_LABEL_OUT(MAX_LABEL_OUT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_valid),
        .i_item     (w_item),
        .o_take     (w_take),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_character(o_character),
        .o_last_res (o_last_res),
        .o_overflow (o_overflow)
    );
endmodule
`default_nettype wire
